// File: hdl/h2r_pkg.sv
// h2r_pkg: shared item types, constants and codes of the hsl to rgb converter
// no dependencies
`default_nettype none

package h2r_pkg;

  // input item: hue in 1/16 degree, saturation and lightness in q0.8
  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  lightness;
  } h2r_in_t;

  // result item: 8-bit rgb
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } h2r_out_t;

  // hue wrap: full circle and one 60 degree sector in 1/16 degree units
  localparam int HueFull       = 5760;
  localparam int HueSector     = 960;
  // hue / 5760 = (hue >> 7) / 45
  localparam int HueShift      = 7;
  localparam int HueFullLow    = HueFull >> HueShift;
  localparam int HueRecipShift = 12;
  localparam int HueRecip      = (1 << HueRecipShift) / HueFullLow;

  // half of the sector width, used as the chroma and offset weight
  localparam int ChromaHalf    = HueSector / 2;
  // common denominator of the channel quotient: 480 * 510
  localparam int DivDenom      = ChromaHalf * 510;
  localparam int DivShift      = 6;
  localparam int DivLow        = DivDenom >> DivShift;
  localparam int DivRecipShift = 31;
  localparam longint DivRecipL = (longint'(1) << DivRecipShift) / longint'(DivLow);
  localparam logic [19:0] DivRecip = 20'(DivRecipL);

  // the six 60 degree sectors
  typedef enum logic [2:0] {
    SecRedYel  = 3'd0,
    SecYelGrn  = 3'd1,
    SecGrnCyan = 3'd2,
    SecCyanBlu = 3'd3,
    SecBluMag  = 3'd4,
    SecMagRed  = 3'd5
  } h2r_sector_e;

  // per-stage advance enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } h2r_en_t;

endpackage

`default_nettype wire

// File: hdl/h2r_front.sv
// h2r_front: stages 1 and 2, hue wrap, sector split and chroma numerator
// depends on h2r_pkg
`default_nettype none

module h2r_front (
  input  logic              clk_i,
  input  h2r_pkg::h2r_en_t  en_i,
  input  h2r_pkg::h2r_in_t  in_data_i,
  output logic [15:0]       cn_o,
  output logic [2:0]        sector_o,
  output logic signed [10:0] k_o,
  output logic [7:0]        light_o
);
  import h2r_pkg::*;

  // stage 1 signals
  logic [8:0]  hx;
  logic [15:0] est_prod;
  logic [3:0]  est1;
  logic [8:0]  rem1;
  logic [3:0]  quo1;
  logic [15:0] wrap_sub;
  logic [8:0]  twol;
  logic [7:0]  lum_dev;
  logic [12:0] h1_d, h1_q;
  logic [7:0]  s1_q, l1_q;
  logic [7:0]  cw1_d, cw1_q;

  // stage 2 signals
  logic [2:0]  sec2_d;
  logic [12:0] base2;
  logic [9:0]  f2;
  logic [10:0] g2;
  logic [15:0] cn2_d;
  logic signed [10:0] k2_d;
  logic [15:0] cn2_q;
  logic [2:0]  sec2_q;
  logic signed [10:0] k2_q;
  logic [7:0]  l2_q;

  // hue mod 5760 through a reciprocal estimate and one correction
  always_comb begin
    hx       = in_data_i.hue[15:HueShift];
    est_prod = 16'(hx) * 16'(HueRecip);
    est1     = est_prod[HueRecipShift +: 4];
    rem1     = hx - 9'(est1 * 9'(HueFullLow));
    quo1     = (rem1 >= 9'(HueFullLow)) ? est1 + 4'd1 : est1;
    wrap_sub = in_data_i.hue - 16'(quo1 * 16'(HueFull));
    h1_d     = wrap_sub[12:0];
    twol     = {in_data_i.lightness, 1'b0};
    lum_dev  = (twol >= 9'd255) ? 8'(twol - 9'd255) : 8'(9'd255 - twol);
    cw1_d    = 8'd255 - lum_dev;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      h1_q  <= h1_d;
      s1_q  <= in_data_i.saturation;
      l1_q  <= in_data_i.lightness;
      cw1_q <= cw1_d;
    end
  end

  // sector and position inside it, chroma numerator
  always_comb begin
    priority if (h1_q < 13'(HueSector))     sec2_d = SecRedYel;
    else if     (h1_q < 13'(2 * HueSector)) sec2_d = SecYelGrn;
    else if     (h1_q < 13'(3 * HueSector)) sec2_d = SecGrnCyan;
    else if     (h1_q < 13'(4 * HueSector)) sec2_d = SecCyanBlu;
    else if     (h1_q < 13'(5 * HueSector)) sec2_d = SecBluMag;
    else                                    sec2_d = SecMagRed;
    base2 = 13'(sec2_d * 13'(HueSector));
    f2    = 10'(h1_q - base2);
    // odd sectors run the second component downward
    g2    = sec2_d[0] ? 11'(HueSector) - 11'(f2) : 11'(f2);
    k2_d  = $signed(g2) - 11'sd480;
    cn2_d = 16'(cw1_q) * 16'(s1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      cn2_q  <= cn2_d;
      sec2_q <= sec2_d;
      k2_q   <= k2_d;
      l2_q   <= l1_q;
    end
  end

  assign cn_o     = cn2_q;
  assign sector_o = sec2_q;
  assign k_o      = k2_q;
  assign light_o  = l2_q;

endmodule

`default_nettype wire

// File: hdl/h2r_mix.sv
// h2r_mix: stages 3 and 4, component products and per-channel dividend
// depends on h2r_pkg
`default_nettype none

module h2r_mix (
  input  logic               clk_i,
  input  h2r_pkg::h2r_en_t   en_i,
  input  logic [15:0]        cn_i,
  input  logic [2:0]         sector_i,
  input  logic signed [10:0] k_i,
  input  logic [7:0]         light_i,
  output logic [2:0][18:0]   y_o,
  output logic [2:0]         neg_o,
  output logic [7:0]         light_o
);
  import h2r_pkg::*;

  localparam logic [2:0] SelC = 3'b001;
  localparam logic [2:0] SelX = 3'b010;
  localparam logic [2:0] SelZ = 3'b100;

  logic signed [27:0] pk_full;
  logic signed [25:0] pk3_q;
  logic [24:0]        pc3_d, pc3_q;
  logic [2:0]         sec3_q;
  logic [7:0]         l3_q;

  logic [25:0]        mag_x;
  logic [25:0]        bias_x, bias_z;
  logic [18:0]        y_c, y_x, y_z;
  logic               neg_x;
  logic [2:0][2:0]    sel;
  logic [2:0][18:0]   y4_d, y4_q;
  logic [2:0]         neg4_d, neg4_q;
  logic [7:0]         l4_q;

  always_comb begin
    pk_full = $signed({1'b0, cn_i}) * k_i;
    pc3_d   = 25'(cn_i) * 25'(ChromaHalf);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      pk3_q  <= 26'(pk_full);
      pc3_q  <= pc3_d;
      sec3_q <= sector_i;
      l3_q   <= light_i;
    end
  end

  // floor of a negative quotient: bias the magnitude up by denom - 1
  always_comb begin
    neg_x  = pk3_q[25];
    mag_x  = neg_x ? 26'(-pk3_q) : 26'(pk3_q);
    bias_x = mag_x + (neg_x ? 26'(DivDenom - 1) : 26'd0);
    bias_z = 26'(pc3_q) + 26'(DivDenom - 1);
    y_c    = 19'(pc3_q >> DivShift);
    y_x    = 19'(bias_x >> DivShift);
    y_z    = 19'(bias_z >> DivShift);

    // channel order: red, green, blue at index 2, 1, 0
    unique case (sec3_q)
      SecRedYel:  sel = {SelC, SelX, SelZ};
      SecYelGrn:  sel = {SelX, SelC, SelZ};
      SecGrnCyan: sel = {SelZ, SelC, SelX};
      SecCyanBlu: sel = {SelZ, SelX, SelC};
      SecBluMag:  sel = {SelX, SelZ, SelC};
      default:    sel = {SelC, SelZ, SelX};
    endcase

    for (int i = 0; i < 3; i++) begin
      unique case (sel[i])
        SelC: begin
          y4_d[i]   = y_c;
          neg4_d[i] = 1'b0;
        end
        SelX: begin
          y4_d[i]   = y_x;
          neg4_d[i] = neg_x;
        end
        default: begin
          y4_d[i]   = y_z;
          neg4_d[i] = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      y4_q   <= y4_d;
      neg4_q <= neg4_d;
      l4_q   <= l3_q;
    end
  end

  assign y_o     = y4_q;
  assign neg_o   = neg4_q;
  assign light_o = l4_q;

endmodule

`default_nettype wire

// File: hdl/h2r_chan_div.sv
// h2r_chan_div: stages 5 and 6 of one channel, quotient by the constant
// denominator, offset by lightness and clamp; depends on h2r_pkg
`default_nettype none

module h2r_chan_div (
  input  logic             clk_i,
  input  h2r_pkg::h2r_en_t en_i,
  input  logic [18:0]      y_i,
  input  logic             neg_i,
  input  logic [7:0]       light_i,
  output logic [7:0]       chan_o
);
  import h2r_pkg::*;

  logic [38:0] prod5;
  logic [7:0]  est5_d, est5_q;
  logic [18:0] y5_q;
  logic        neg5_q;
  logic [7:0]  l5_q;

  logic [19:0] back6;
  logic [19:0] rem6;
  logic [8:0]  quo6;
  logic signed [10:0] val6;
  logic [7:0]  ch6_d, ch6_q;

  // reciprocal estimate, low by at most one
  always_comb begin
    prod5  = 39'(y_i) * 39'(DivRecip);
    est5_d = 8'(prod5 >> DivRecipShift);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      est5_q <= est5_d;
      y5_q   <= y_i;
      neg5_q <= neg_i;
      l5_q   <= light_i;
    end
  end

  always_comb begin
    back6 = 20'(est5_q) * 20'(DivLow);
    rem6  = 20'(y5_q) - back6;
    quo6  = (rem6 >= 20'(DivLow)) ? 9'(est5_q) + 9'd1 : 9'(est5_q);
    val6  = neg5_q ? $signed(11'(l5_q)) - $signed(11'(quo6))
                   : $signed(11'(l5_q)) + $signed(11'(quo6));
    priority if (val6 < 11'sd0)   ch6_d = 8'd0;
    else if     (val6 > 11'sd255) ch6_d = 8'd255;
    else                          ch6_d = val6[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s6) begin
      ch6_q <= ch6_d;
    end
  end

  assign chan_o = ch6_q;

endmodule

`default_nettype wire

// File: hdl/hsl_to_rgb_converter_core.sv
// hsl_to_rgb_converter_core: top level of the hsl to rgb color converter
// depends on h2r_pkg, h2r_front, h2r_mix and h2r_chan_div
//
// Converts one hsl color per item into 8-bit rgb. Hue is in 1/16 degree
// units and wraps modulo 360 degrees; saturation and lightness are q0.8
// with 255 meaning 1.0. Results are exact: each channel is the truncated
// (component + offset) * 255, clamped to 0..255. The block is a six stage
// pipeline that takes one item per clock while in_stall_o is low. Each stage
// holds one item and a valid bit; a stalled output only holds the stages
// behind it that are full, so empty stages keep taking new items and the
// input stalls only once every stage ahead is occupied. Stages: hue wrap and
// lightness distance, sector split and chroma product, component products,
// per-channel dividend, reciprocal quotient estimate, correction with offset
// and clamp into the output register.
`default_nettype none

module hsl_to_rgb_converter_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  h2r_pkg::h2r_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output h2r_pkg::h2r_out_t out_data_o
);
  import h2r_pkg::*;

  // valid bit of each stage, index 0 is stage 1
  logic [5:0] valid_d, valid_q;
  h2r_en_t    en;

  // stage 2 outputs
  logic [15:0]        cn;
  logic [2:0]         sector;
  logic signed [10:0] k;
  logic [7:0]         light2;

  // stage 4 outputs
  logic [2:0][18:0]   y;
  logic [2:0]         neg;
  logic [7:0]         light4;

  // a stage advances when it is empty or the stage ahead advances
  always_comb begin
    en.s6 = !valid_q[5] || !out_stall_i;
    en.s5 = !valid_q[4] || en.s6;
    en.s4 = !valid_q[3] || en.s5;
    en.s3 = !valid_q[2] || en.s4;
    en.s2 = !valid_q[1] || en.s3;
    en.s1 = !valid_q[0] || en.s2;
  end

  // valid bits follow the items through the stages
  always_comb begin
    valid_d    = valid_q;
    if (en.s1) valid_d[0] = in_valid_i;
    if (en.s2) valid_d[1] = valid_q[0];
    if (en.s3) valid_d[2] = valid_q[1];
    if (en.s4) valid_d[3] = valid_q[2];
    if (en.s5) valid_d[4] = valid_q[3];
    if (en.s6) valid_d[5] = valid_q[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  h2r_front u_front (
    .clk_i     (clk_i),
    .en_i      (en),
    .in_data_i (in_data_i),
    .cn_o      (cn),
    .sector_o  (sector),
    .k_o       (k),
    .light_o   (light2)
  );

  h2r_mix u_mix (
    .clk_i    (clk_i),
    .en_i     (en),
    .cn_i     (cn),
    .sector_i (sector),
    .k_i      (k),
    .light_i  (light2),
    .y_o      (y),
    .neg_o    (neg),
    .light_o  (light4)
  );

  // one divider lane per channel
  h2r_chan_div u_div_red (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (y[2]),
    .neg_i   (neg[2]),
    .light_i (light4),
    .chan_o  (out_data_o.red)
  );

  h2r_chan_div u_div_green (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (y[1]),
    .neg_i   (neg[1]),
    .light_i (light4),
    .chan_o  (out_data_o.green)
  );

  h2r_chan_div u_div_blue (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (y[0]),
    .neg_i   (neg[0]),
    .light_i (light4),
    .chan_o  (out_data_o.blue)
  );

  assign in_stall_o  = !en.s1;
  assign out_valid_o = valid_q[5];

endmodule

`default_nettype wire

// File: hdl/h2r_checker.sv
// h2r_checker: port-level checks of the hsl to rgb converter, bound to the top
// depends on h2r_pkg and hsl_to_rgb_converter_core
`default_nettype none

module h2r_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input h2r_pkg::h2r_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input h2r_pkg::h2r_out_t out_data_o
);
  import h2r_pkg::*;

  // history of cycles with the output free, cleared by reset
  logic [5:0] free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '0;
    end else begin
      free_q <= {free_q[4:0], !out_stall_i};
    end
  end

  // with no output stall the pipeline runs at full speed and an accepted item reaches the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&free_q) && $past(in_valid_i && !in_stall_o, 6)) |-> out_valid_o)
    else $error("accepted item did not arrive after six free cycles");

  // an empty output stage means every stage can move
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the output stage is empty");

  // zero saturation gives grey at the lightness level
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&free_q) && $past(in_valid_i && !in_stall_o, 6)
      && ($past(in_data_i.saturation, 6) == 8'd0))
    |-> ((out_data_o.red == $past(in_data_i.lightness, 6))
      && (out_data_o.green == $past(in_data_i.lightness, 6))
      && (out_data_o.blue == $past(in_data_i.lightness, 6))))
    else $error("grey item did not keep its lightness");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind hsl_to_rgb_converter_core h2r_checker u_h2r_checker (.*);

`default_nettype wire
